// ===== rtl/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// TEA cipher package
// Shared types and constants for the pipelined TEA block cipher.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned CELLS     = 2 * ROUNDS;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e37_79b9;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [KEY_WORDS-1:0] key_t;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD_0 = 2'd0,
        REG_KEY_WORD_1 = 2'd1,
        REG_KEY_WORD_2 = 2'd2,
        REG_KEY_WORD_3 = 2'd3
    } cfg_reg_t;

    // One block in flight through the chain.
    typedef struct packed {
        op_t   op;
        word_t left;
        word_t right;
    } block_t;

    // Round sum seen by round r when encrypting.
    function automatic word_t enc_sum(input int unsigned r);
        return word_t'(DELTA * word_t'(r + 1));
    endfunction

    // Round sum seen by round r when decrypting.
    function automatic word_t dec_sum(input int unsigned r);
        return word_t'(DELTA * word_t'(ROUNDS - r));
    endfunction

endpackage

// ===== rtl/tea_cell.sv =====
// ----------------------------------------------------------------------------
// TEA half-round cell
// Updates one word of the block from the other and passes it on.
// ----------------------------------------------------------------------------
module tea_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           phase,
    input  tea_pkg::word_t sum_enc,
    input  tea_pkg::word_t sum_dec,
    input  tea_pkg::key_t  key,
    input  logic           in_valid,
    input  tea_pkg::block_t in_block,
    output logic           out_valid,
    output tea_pkg::block_t out_block
);
    import tea_pkg::*;

    logic   valid_reg;
    block_t block_reg;
    block_t block_next;
    logic   upd_left;
    word_t  src;
    word_t  dst;
    word_t  sum;
    word_t  ka;
    word_t  kb;
    word_t  mixed;
    word_t  res;

    function automatic word_t mix(input word_t v, input word_t s,
                                  input word_t a, input word_t b);
        return ((v << 4) + a) ^ (v + s) ^ ((v >> 5) + b);
    endfunction

    always_comb begin
        // encrypt updates left then right; decrypt undoes right then left
        upd_left   = ~((in_block.op == OP_DECRYPT) ^ phase);
        sum        = (in_block.op == OP_DECRYPT) ? sum_dec : sum_enc;
        src        = upd_left ? in_block.right : in_block.left;
        dst        = upd_left ? in_block.left : in_block.right;
        ka         = upd_left ? key[0] : key[2];
        kb         = upd_left ? key[1] : key[3];
        mixed      = mix(src, sum, ka, kb);
        res        = (in_block.op == OP_DECRYPT) ? dst - mixed : dst + mixed;
        block_next = in_block;
        if (upd_left) begin
            block_next.left = res;
        end else begin
            block_next.right = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            block_reg <= block_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_block = block_reg;

endmodule

// ===== rtl/tea_block_cipher_top.sv =====
// ----------------------------------------------------------------------------
// TEA block cipher, top level
// Fully pipelined TEA encrypt/decrypt with a 128-bit key from config regs.
// ----------------------------------------------------------------------------
// Takes one 64-bit block per cycle while the output is not stalled: the 32
// rounds are a row of 64 half-round cells, each holding one block, and all
// cells move together. The last cell is the output register; while its word
// waits for m_ready the whole row holds and s_ready is low. Encrypt and
// decrypt blocks may be mixed freely. Write the key words only while no
// block is in flight.
module tea_block_cipher_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tea_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  tea_pkg::word_t                  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  tea_pkg::word_t                  s_block_left,
    input  tea_pkg::word_t                  s_block_right,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tea_pkg::word_t                  m_out_left,
    output tea_pkg::word_t                  m_out_right
);
    import tea_pkg::*;

    key_t   key_reg;
    logic   advance;
    logic   valid_chain [0:CELLS];
    block_t block_chain [0:CELLS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_WORD_0: key_reg[0] <= cfg_wdata;
                REG_KEY_WORD_1: key_reg[1] <= cfg_wdata;
                REG_KEY_WORD_2: key_reg[2] <= cfg_wdata;
                REG_KEY_WORD_3: key_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // hold the row while the output word is stalled
    assign advance = !valid_chain[CELLS] || m_ready;
    assign s_ready = advance;

    assign valid_chain[0]       = s_valid;
    assign block_chain[0].op    = op_t'(s_operation);
    assign block_chain[0].left  = s_block_left;
    assign block_chain[0].right = s_block_right;

    for (genvar c = 0; c < CELLS; c++) begin : g_cell
        tea_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .phase     (1'(c % 2)),
            .sum_enc   (enc_sum(c / 2)),
            .sum_dec   (dec_sum(c / 2)),
            .key       (key_reg),
            .in_valid  (valid_chain[c]),
            .in_block  (block_chain[c]),
            .out_valid (valid_chain[c+1]),
            .out_block (block_chain[c+1])
        );
    end

    assign m_valid     = valid_chain[CELLS];
    assign m_out_left  = block_chain[CELLS].left;
    assign m_out_right = block_chain[CELLS].right;

endmodule

// ===== rtl/tea_checker.sv =====
// ----------------------------------------------------------------------------
// TEA cipher port checker
// Watches the top-level ports for flow-control slips.
// ----------------------------------------------------------------------------
module tea_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_ready,
    input  logic           m_valid,
    input  logic           m_ready,
    input  tea_pkg::word_t m_out_left,
    input  tea_pkg::word_t m_out_right
);
    import tea_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_left)
            && $stable(m_out_right))
        else $error("result word changed while stalled");

    // input side opens exactly when the output register can move
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not track output stall");

    // reset empties the chain
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind tea_block_cipher_top tea_checker u_tea_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_left  (m_out_left),
    .m_out_right (m_out_right)
);
